[sv/kdkn_pkg.sv]
`default_nettype none
package kdkn_pkg;
	localparam int TREE_NODES = 1024;
	localparam int K_MAX = 16;
	localparam int COORD_BITS = 24;
	localparam int NODE_W = 11;
	localparam int ADDR_W = 10;
	localparam int DIST_W = 48;
	localparam int CADDR_W = 4;
	localparam int CNT_W = 5;
	localparam int STK_DEPTH = 16;
	localparam int STK_W = 4;
	localparam int IN_W = 144;
	localparam int OUT_W = 112;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [0:0] ACT_LOAD = 1'b0;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [1:0] phase;
	} stk_ent_t;

	typedef enum logic [4:0] {
		S_IDLE, S_FETCH, S_PLANE, S_PSQ1, S_PSQ2,
		S_D1, S_D2, S_D3, S_D4, S_CMP,
		S_HLD, S_HLD2, S_SJ, S_SJ1, S_SJ2, S_SCMP, S_SEND,
		S_RAD1, S_RAD2, S_ORD, S_OLD, S_OWAIT
	} state_t;

	function automatic logic [DIST_W-1:0] sq_sat(input logic signed [COORD_BITS:0] d);
		logic [COORD_BITS:0] a;
		a = d[COORD_BITS] ? (~d + 1'b1) : d;
		if (a[COORD_BITS])
			return DIST_MAX;
		return DIST_W'(a[COORD_BITS-1:0]) * DIST_W'(a[COORD_BITS-1:0]);
	endfunction

	function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
			input logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
	endfunction
endpackage
`default_nettype wire

[sv/kd_tree_k_nearest_search.sv]
// Load word: accepted, no result.
// Query: leaf tests and inner-node plane tests all go through one shared squaring unit,
// and a candidate-list update walks the heap one level at a time. Results then leave
// one word at a time, each held until m_tready. Ready only while idle.
// Reset (arst_n low, async) clears control, node_count and the output valid;
// tree and candidate memories hold no reset value.
`default_nettype none
module kd_tree_k_nearest_search import kdkn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// node_index, pos_x, pos_y, pos_z, split_axis, max_dist2, want_count
	input  wire logic [IN_W-1:0] s_tdata,
	// action
	input  wire logic s_tuser,
	output logic m_tvalid,
	input  wire logic m_tready,
	// found_node, found_dist2, radius2
	output logic [OUT_W-1:0] m_tdata,
	// found
	output logic m_tuser,
	output logic m_tlast,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [NODE_W-1:0] cfg_data
);
	state_t state_q, state_d;
	logic [NODE_W-1:0] nc_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q, qx_d, qy_d, qz_d;
	logic [DIST_W-1:0] rad_q, rad_d, acc_q, acc_d, sq_q;
	logic [CNT_W-1:0] k_q, k_d, tot_q, tot_d, par_q, par_d, kk_q, kk_d, oi_q, oi_d;
	logic [CNT_W:0] j_q, j_d;
	logic hr_q, hr_d, strict_q, strict_d, d1pos_q, d1pos_d;
	logic signed [COORD_BITS:0] diff_q, diff_d;
	logic [CNT_W-1:0] sp_q, sp_d;
	stk_ent_t stk_q [STK_DEPTH];
	logic top_we, push_we;
	stk_ent_t top_wd, push_wd;
	logic [DIST_W-1:0] el_d_q, el_d_d, cj_d_q, cj_d_d;
	logic [NODE_W-1:0] el_n_q, el_n_d, cj_n_q, cj_n_d;
	logic ov_q, ov_d, ofound_q, ofound_d, olast_q, olast_d;
	logic [NODE_W-1:0] onode_q, onode_d;
	logic [DIST_W-1:0] odist_q, odist_d, orad_q, orad_d;

	logic signed [COORD_BITS-1:0] mem_x [TREE_NODES];
	logic signed [COORD_BITS-1:0] mem_y [TREE_NODES];
	logic signed [COORD_BITS-1:0] mem_z [TREE_NODES];
	logic [1:0] mem_a [TREE_NODES];
	logic signed [COORD_BITS-1:0] rx_q, ry_q, rz_q;
	logic [1:0] ra_q;
	logic t_we, t_re;
	logic [ADDR_W-1:0] t_ra, t_wa;

	logic [DIST_W-1:0] cmem_d [K_MAX];
	logic [NODE_W-1:0] cmem_n [K_MAX];
	logic [DIST_W-1:0] cr_d_q;
	logic [NODE_W-1:0] cr_n_q;
	logic c_we, c_re;
	logic [CADDR_W-1:0] c_wa, c_ra;
	logic [DIST_W-1:0] c_wd;
	logic [NODE_W-1:0] c_wn;

	logic [NODE_W-1:0] in_idx;
	logic [DIST_W-1:0] in_rad;
	logic [CNT_W-1:0] in_k;
	logic [NODE_W-1:0] nc_lim;
	logic [NODE_W:0] inner_lim;
	logic [CNT_W-1:0] spm1;
	stk_ent_t top;
	logic inner;
	logic signed [COORD_BITS-1:0] qa, ca;
	logic signed [COORD_BITS:0] d1;
	logic [NODE_W-1:0] first_n, second_n;
	logic brk;

	assign in_idx = s_tdata[10:0];
	assign in_rad = s_tdata[132:85];
	assign in_k = s_tdata[137:133];
	assign nc_lim = (nc_q > NODE_W'(TREE_NODES)) ? NODE_W'(TREE_NODES) : nc_q;
	assign inner_lim = {2'b0, nc_lim[NODE_W-1:1]};
	assign spm1 = sp_q - 1'b1;
	assign top = stk_q[spm1[STK_W-1:0]];
	assign inner = ({1'b0, top.node} + 1'b1) < inner_lim && top.phase < 2'd2;
	assign qa = (ra_q == AX_X) ? qx_q : (ra_q == AX_Y) ? qy_q : qz_q;
	assign ca = (ra_q == AX_X) ? rx_q : (ra_q == AX_Y) ? ry_q : rz_q;
	assign d1 = {qa[COORD_BITS-1], qa} - {ca[COORD_BITS-1], ca};
	assign first_n = (d1 > 0) ? {top.node[NODE_W-2:0], 1'b1} : {top.node[NODE_W-2:0], 1'b0};
	assign second_n = d1pos_q ? {top.node[NODE_W-2:0], 1'b0} : {top.node[NODE_W-2:0], 1'b1};
	assign brk = strict_q ? (el_d_q > cj_d_q) : (el_d_q >= cj_d_q);

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = ov_q;
	assign m_tdata = {5'b0, orad_q, odist_q, onode_q};
	assign m_tuser = ofound_q;
	assign m_tlast = olast_q;

	always_comb begin
		state_d = state_q;
		qx_d = qx_q; qy_d = qy_q; qz_d = qz_q;
		rad_d = rad_q; acc_d = acc_q; k_d = k_q; tot_d = tot_q;
		par_d = par_q; kk_d = kk_q; oi_d = oi_q; j_d = j_q;
		hr_d = hr_q; strict_d = strict_q; d1pos_d = d1pos_q; diff_d = diff_q;
		sp_d = sp_q;
		el_d_d = el_d_q; el_n_d = el_n_q; cj_d_d = cj_d_q; cj_n_d = cj_n_q;
		ov_d = ov_q; ofound_d = ofound_q; olast_d = olast_q;
		onode_d = onode_q; odist_d = odist_q; orad_d = orad_q;
		top_we = 1'b0; push_we = 1'b0;
		top_wd = top; push_wd = top;
		t_we = 1'b0; t_re = 1'b0;
		t_wa = in_idx[ADDR_W-1:0]; t_ra = top.node[ADDR_W-1:0];
		c_we = 1'b0; c_re = 1'b0;
		c_wa = par_q[CADDR_W-1:0]; c_ra = par_q[CADDR_W-1:0];
		c_wd = el_d_q; c_wn = el_n_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == ACT_LOAD) begin
						t_we = (in_idx != '0) && (in_idx <= NODE_W'(TREE_NODES));
					end else begin
						qx_d = s_tdata[34:11];
						qy_d = s_tdata[58:35];
						qz_d = s_tdata[82:59];
						rad_d = in_rad;
						k_d = (in_k == '0) ? CNT_W'(1) :
							(in_k > CNT_W'(K_MAX)) ? CNT_W'(K_MAX) : in_k;
						tot_d = '0;
						hr_d = 1'b0;
						if (nc_lim != '0) begin
							sp_d = CNT_W'(1);
							push_we = 1'b1;
							push_wd = '{node: NODE_W'(1), phase: 2'd0};
							state_d = S_FETCH;
						end else begin
							ov_d = 1'b1; ofound_d = 1'b0; olast_d = 1'b1;
							onode_d = '0; odist_d = '0; orad_d = in_rad;
							state_d = S_OWAIT;
						end
					end
				end
			end
			S_FETCH: begin
				t_re = 1'b1;
				state_d = S_PLANE;
			end
			S_PLANE: begin
				if (inner) begin
					d1pos_d = (d1 > 0);
					if (top.phase == 2'd0) begin
						top_we = 1'b1;
						top_wd = '{node: top.node, phase: 2'd1};
						push_we = 1'b1;
						push_wd = '{node: first_n, phase: 2'd0};
						sp_d = sp_q + 1'b1;
						state_d = S_FETCH;
					end else begin
						diff_d = d1;
						state_d = S_PSQ1;
					end
				end else begin
					diff_d = {qx_q[COORD_BITS-1], qx_q} - {rx_q[COORD_BITS-1], rx_q};
					state_d = S_D1;
				end
			end
			S_PSQ1: state_d = S_PSQ2;
			S_PSQ2: begin
				if (sq_q < rad_q) begin
					top_we = 1'b1;
					top_wd = '{node: top.node, phase: 2'd2};
					push_we = 1'b1;
					push_wd = '{node: second_n, phase: 2'd0};
					sp_d = sp_q + 1'b1;
					state_d = S_FETCH;
				end else begin
					diff_d = {qx_q[COORD_BITS-1], qx_q} - {rx_q[COORD_BITS-1], rx_q};
					state_d = S_D1;
				end
			end
			S_D1: begin
				diff_d = {qy_q[COORD_BITS-1], qy_q} - {ry_q[COORD_BITS-1], ry_q};
				state_d = S_D2;
			end
			S_D2: begin
				acc_d = sq_q;
				diff_d = {qz_q[COORD_BITS-1], qz_q} - {rz_q[COORD_BITS-1], rz_q};
				state_d = S_D3;
			end
			S_D3: begin
				acc_d = add_sat(acc_q, sq_q);
				state_d = S_D4;
			end
			S_D4: begin
				acc_d = add_sat(acc_q, sq_q);
				state_d = S_CMP;
			end
			S_CMP: begin
				if (acc_q >= rad_q) begin
					sp_d = spm1;
					state_d = (sp_q == CNT_W'(1)) ? S_ORD : S_FETCH;
					oi_d = CNT_W'(1);
				end else if (tot_q < k_q) begin
					c_we = 1'b1;
					c_wa = CADDR_W'(tot_q + 1'b1);
					c_wd = acc_q;
					c_wn = top.node;
					tot_d = tot_q + 1'b1;
					sp_d = spm1;
					state_d = (sp_q == CNT_W'(1)) ? S_ORD : S_FETCH;
					oi_d = CNT_W'(1);
				end else if (!hr_q && tot_q[CNT_W-1:1] != '0) begin
					kk_d = {1'b0, tot_q[CNT_W-1:1]};
					state_d = S_HLD;
				end else begin
					hr_d = 1'b1;
					el_d_d = acc_q; el_n_d = top.node;
					par_d = CNT_W'(1); strict_d = 1'b1;
					state_d = S_SJ;
				end
			end
			S_HLD: begin
				c_re = 1'b1;
				c_ra = kk_q[CADDR_W-1:0];
				state_d = S_HLD2;
			end
			S_HLD2: begin
				el_d_d = cr_d_q; el_n_d = cr_n_q;
				par_d = kk_q; strict_d = 1'b0;
				state_d = S_SJ;
			end
			S_SJ: begin
				j_d = {par_q, 1'b0};
				if ({par_q, 1'b0} > {1'b0, tot_q}) begin
					state_d = S_SEND;
				end else begin
					c_re = 1'b1;
					c_ra = {par_q[CADDR_W-2:0], 1'b0};
					state_d = S_SJ1;
				end
			end
			S_SJ1: begin
				cj_d_d = cr_d_q; cj_n_d = cr_n_q;
				if (j_q < {1'b0, tot_q}) begin
					c_re = 1'b1;
					c_ra = CADDR_W'(j_q + 1'b1);
					state_d = S_SJ2;
				end else begin
					state_d = S_SCMP;
				end
			end
			S_SJ2: begin
				if (cj_d_q < cr_d_q) begin
					cj_d_d = cr_d_q; cj_n_d = cr_n_q;
					j_d = j_q + 1'b1;
				end
				state_d = S_SCMP;
			end
			S_SCMP: begin
				if (brk) begin
					state_d = S_SEND;
				end else begin
					c_we = 1'b1;
					c_wd = cj_d_q; c_wn = cj_n_q;
					par_d = j_q[CNT_W-1:0];
					state_d = S_SJ;
				end
			end
			S_SEND: begin
				c_we = 1'b1;
				if (strict_q) begin
					state_d = S_RAD1;
				end else if (kk_q == CNT_W'(1)) begin
					hr_d = 1'b1;
					el_d_d = acc_q; el_n_d = top.node;
					par_d = CNT_W'(1); strict_d = 1'b1;
					state_d = S_SJ;
				end else begin
					kk_d = kk_q - 1'b1;
					state_d = S_HLD;
				end
			end
			S_RAD1: begin
				c_re = 1'b1;
				c_ra = CADDR_W'(1);
				state_d = S_RAD2;
			end
			S_RAD2: begin
				rad_d = cr_d_q;
				sp_d = spm1;
				oi_d = CNT_W'(1);
				state_d = (sp_q == CNT_W'(1)) ? S_ORD : S_FETCH;
			end
			S_ORD: begin
				if (tot_q == '0) begin
					ov_d = 1'b1; ofound_d = 1'b0; olast_d = 1'b1;
					onode_d = '0; odist_d = '0; orad_d = rad_q;
					state_d = S_OWAIT;
				end else begin
					c_re = 1'b1;
					c_ra = oi_q[CADDR_W-1:0];
					state_d = S_OLD;
				end
			end
			S_OLD: begin
				ov_d = 1'b1; ofound_d = 1'b1; olast_d = (oi_q == tot_q);
				onode_d = cr_n_q; odist_d = cr_d_q; orad_d = rad_q;
				state_d = S_OWAIT;
			end
			S_OWAIT: begin
				if (m_tready) begin
					ov_d = 1'b0;
					oi_d = oi_q + 1'b1;
					state_d = olast_q ? S_IDLE : S_ORD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nc_q <= '0;
			tot_q <= '0;
			hr_q <= 1'b0;
			sp_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid)
				nc_q <= cfg_data;
			tot_q <= tot_d;
			hr_q <= hr_d;
			sp_q <= sp_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		qx_q <= qx_d; qy_q <= qy_d; qz_q <= qz_d;
		rad_q <= rad_d; acc_q <= acc_d; k_q <= k_d;
		par_q <= par_d; kk_q <= kk_d; oi_q <= oi_d; j_q <= j_d;
		strict_q <= strict_d; d1pos_q <= d1pos_d; diff_q <= diff_d;
		sq_q <= sq_sat(diff_q);
		el_d_q <= el_d_d; el_n_q <= el_n_d; cj_d_q <= cj_d_d; cj_n_q <= cj_n_d;
		ofound_q <= ofound_d; olast_q <= olast_d;
		onode_q <= onode_d; odist_q <= odist_d; orad_q <= orad_d;
		if (top_we)
			stk_q[spm1[STK_W-1:0]] <= top_wd;
		if (push_we)
			stk_q[sp_q[STK_W-1:0]] <= push_wd;
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			mem_x[t_wa] <= s_tdata[34:11];
			mem_y[t_wa] <= s_tdata[58:35];
			mem_z[t_wa] <= s_tdata[82:59];
			mem_a[t_wa] <= s_tdata[84:83];
		end
		if (t_re) begin
			rx_q <= mem_x[t_ra];
			ry_q <= mem_y[t_ra];
			rz_q <= mem_z[t_ra];
			ra_q <= mem_a[t_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem_d[c_wa] <= c_wd;
			cmem_n[c_wa] <= c_wn;
		end
		if (c_re) begin
			cr_d_q <= cmem_d[c_ra];
			cr_n_q <= cmem_n[c_ra];
		end
	end

	a_tot_le_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (tot_q <= k_q))
		else $error("candidate count above k");
	a_ready_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("ready while a result word is pending");
	a_stack_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> (sp_q != '0 && sp_q <= CNT_W'(STK_DEPTH)))
		else $error("walk stack pointer out of range");
endmodule
`default_nettype wire
